### sv/csvt_pkg.sv
// csvt_pkg: shared types and constants of the CSV field tokenizer.
// No dependencies; used by every module of the block.
package csvt_pkg;

    localparam int POS_BITS_DEF   = 32;
    localparam int FIDX_BITS_DEF  = 16;
    localparam int APB_ADDR_BITS  = 4;
    localparam int APB_DATA_BITS  = 32;
    localparam int TDATA_IN_BITS  = 8;
    localparam int TDATA_OUT_BITS = 184;
    localparam int TUSER_OUT_BITS = 2;

    localparam logic [7:0] QUOTE_RST = 8'd34;
    localparam logic [7:0] ESC_RST   = 8'd0;
    localparam logic [7:0] DELIM_RST = 8'd44;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    localparam logic [1:0] REG_QUOTE = 2'd0;
    localparam logic [1:0] REG_ESC   = 2'd1;
    localparam logic [1:0] REG_DELIM = 2'd2;

    typedef enum logic [3:0] {
        MODE_PLAIN  = 4'b0001,
        MODE_QUOTED = 4'b0010,
        MODE_QPEND  = 4'b0100,
        MODE_EPEND  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [7:0] quote_char;
        logic [7:0] escape_char;
        logic [7:0] delim_char;
    } t_cfg;

    typedef struct packed {
        logic        field_valid;
        logic [31:0] field_start;
        logic [31:0] field_length;
        logic        field_quoted;
        logic [15:0] field_index;
        logic [31:0] row_index;
        logic        row_end;
        logic        buffer_done;
        logic [31:0] consumed_bytes;
        logic [31:0] rows_complete;
        logic        no_complete_row;
    } t_res;

endpackage

### sv/csv_field_tokenizer.sv
// csv_field_tokenizer: top level; input register, tokenizer core, result register
// and APB configuration. Depends on csvt_pkg, csvt_regs, csvt_core.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tdata data_byte, tlast end_of_buffer
//   m_axis    out  tvalid/tready             tdata/tuser/tlast result fields
//   apb       in   psel/penable/pwrite       paddr, pwdata, prdata; pready tied high
//
// One byte per cycle sustained while m_axis accepts results; a byte passes through the input
// register into the core, and its result is captured in the result register.
// Bytes that close no field and are not the buffer end give no result transfer.
// A stalled m_axis holds the result; the input register holds one more byte.
// Synchronous active-low reset clears mode, counters and both valid flags.
module csv_field_tokenizer #(
    parameter int POS_BITS         = csvt_pkg::POS_BITS_DEF,
    parameter int FIELD_INDEX_BITS = csvt_pkg::FIDX_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] data_byte
    input  logic [csvt_pkg::TDATA_IN_BITS-1:0]  s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] field_start, [63:32] field_length, [64] field_quoted,
    // [80:65] field_index, [112:81] row_index, [144:113] consumed_bytes,
    // [176:145] rows_complete, [177] no_complete_row, [183:178] zero
    output logic [csvt_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata,
    // [0] field_valid, [1] row_end
    output logic [csvt_pkg::TUSER_OUT_BITS-1:0] m_axis_tuser,
    output logic                                m_axis_tlast,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csvt_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [csvt_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [csvt_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    csvt_pkg::t_cfg w_cfg;
    csvt_pkg::t_res w_res;
    csvt_pkg::t_res r_out;
    logic           w_res_valid;
    logic           w_step;
    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_last;
    logic           r_out_valid;

    csvt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    csvt_core #(
        .POS_BITS         (POS_BITS),
        .FIELD_INDEX_BITS (FIELD_INDEX_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= w_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out.buffer_done;
    assign m_axis_tuser  = {r_out.row_end, r_out.field_valid};
    assign m_axis_tdata  = {6'd0, r_out.no_complete_row, r_out.rows_complete,
                            r_out.consumed_bytes, r_out.row_index, r_out.field_index,
                            r_out.field_quoted, r_out.field_length, r_out.field_start};

endmodule

### sv/csvt_regs.sv
// csvt_regs: APB configuration registers (quote, escape, delimiter bytes).
// Depends on csvt_pkg.
module csvt_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [csvt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [csvt_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [csvt_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output csvt_pkg::t_cfg                     o_cfg
);

    csvt_pkg::t_cfg r_cfg;
    logic           w_wr;
    logic [1:0]     w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quote_char  <= csvt_pkg::QUOTE_RST;
            r_cfg.escape_char <= csvt_pkg::ESC_RST;
            r_cfg.delim_char  <= csvt_pkg::DELIM_RST;
        end else if (w_wr) begin
            case (w_idx)
                csvt_pkg::REG_QUOTE: r_cfg.quote_char  <= pwdata[7:0];
                csvt_pkg::REG_ESC:   r_cfg.escape_char <= pwdata[7:0];
                csvt_pkg::REG_DELIM: r_cfg.delim_char  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            csvt_pkg::REG_QUOTE: prdata = csvt_pkg::APB_DATA_BITS'(r_cfg.quote_char);
            csvt_pkg::REG_ESC:   prdata = csvt_pkg::APB_DATA_BITS'(r_cfg.escape_char);
            csvt_pkg::REG_DELIM: prdata = csvt_pkg::APB_DATA_BITS'(r_cfg.delim_char);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### sv/csvt_core.sv
// csvt_core: quote-state machine, position/index counters and result formation
// for one byte per step. Depends on csvt_pkg.
module csvt_core #(
    parameter int POS_BITS         = csvt_pkg::POS_BITS_DEF,
    parameter int FIELD_INDEX_BITS = csvt_pkg::FIDX_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  csvt_pkg::t_cfg i_cfg,
    input  logic           i_step,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_res_valid,
    output csvt_pkg::t_res o_res
);

    csvt_pkg::t_mode             r_mode, n_mode;
    logic [POS_BITS-1:0]         r_pos, n_pos;
    logic [POS_BITS-1:0]         r_fstart, n_fstart;
    logic                        r_fquoted, n_fquoted;
    logic [FIELD_INDEX_BITS-1:0] r_fidx, n_fidx;
    logic [31:0]                 r_row, n_row;
    logic [POS_BITS-1:0]         r_rstart, n_rstart;
    logic                        r_prev_cr, n_prev_cr;

    logic [7:0]          w_esc;
    logic                w_plain, w_close, w_row;
    logic [POS_BITS-1:0] w_pos_inc, w_len_raw, w_len;
    logic [63:0]         w_fs64, w_len64, w_rs64;
    logic [31:0]         w_fidx32;

    assign w_esc     = (i_cfg.escape_char != 8'd0) ? i_cfg.escape_char : i_cfg.quote_char;
    assign w_pos_inc = (r_pos == '1) ? r_pos : r_pos + POS_BITS'(1);
    assign w_len_raw = r_pos - r_fstart;
    assign w_len     = w_len_raw - POS_BITS'(w_row && (w_len_raw != '0) && r_prev_cr);
    assign w_fs64    = 64'(r_fstart);
    assign w_len64   = 64'(w_len);
    assign w_rs64    = 64'(n_rstart);
    assign w_fidx32  = 32'(r_fidx);

    always_comb begin
        n_mode    = r_mode;
        n_fstart  = r_fstart;
        n_fquoted = r_fquoted;
        n_fidx    = r_fidx;
        n_row     = r_row;
        n_rstart  = r_rstart;
        w_plain   = 1'b0;
        w_close   = 1'b0;
        w_row     = 1'b0;

        case (r_mode)
            csvt_pkg::MODE_QUOTED: begin
                if (i_byte == i_cfg.quote_char || i_byte == w_esc) begin
                    if (i_cfg.quote_char == w_esc)      n_mode = csvt_pkg::MODE_QPEND;
                    else if (i_byte == i_cfg.quote_char) n_mode = csvt_pkg::MODE_PLAIN;
                    else                                 n_mode = csvt_pkg::MODE_EPEND;
                end
            end
            csvt_pkg::MODE_QPEND: begin
                if (i_byte == i_cfg.quote_char) begin
                    n_mode = csvt_pkg::MODE_QUOTED;
                end else begin
                    n_mode  = csvt_pkg::MODE_PLAIN;
                    w_plain = 1'b1;
                end
            end
            csvt_pkg::MODE_EPEND: n_mode = csvt_pkg::MODE_QUOTED;
            default:              w_plain = 1'b1;
        endcase

        if (w_plain) begin
            if (i_byte == i_cfg.quote_char) begin
                n_fquoted = 1'b1;
                n_mode    = csvt_pkg::MODE_QUOTED;
            end else if (i_byte == i_cfg.delim_char) begin
                w_close = 1'b1;
            end else if (i_byte == csvt_pkg::CHAR_LF) begin
                w_close = 1'b1;
                w_row   = 1'b1;
            end
        end

        if (w_close) begin
            n_fstart  = w_pos_inc;
            n_fquoted = 1'b0;
            if (w_row) begin
                n_fidx   = '0;
                n_row    = (r_row == '1) ? r_row : r_row + 32'd1;
                n_rstart = w_pos_inc;
            end else if (r_fidx != '1) begin
                n_fidx = r_fidx + FIELD_INDEX_BITS'(1);
            end
        end

        n_prev_cr = (i_byte == csvt_pkg::CHAR_CR);
        n_pos     = w_pos_inc;
    end

    always_comb begin
        o_res             = '0;
        o_res_valid       = w_close || i_last;
        if (w_close) begin
            o_res.field_valid  = 1'b1;
            o_res.field_start  = w_fs64[31:0];
            o_res.field_length = w_len64[31:0];
            o_res.field_quoted = r_fquoted;
            o_res.field_index  = w_fidx32[15:0];
            o_res.row_index    = r_row;
            o_res.row_end      = w_row;
        end
        if (i_last) begin
            o_res.buffer_done     = 1'b1;
            o_res.consumed_bytes  = w_rs64[31:0];
            o_res.rows_complete   = n_row;
            o_res.no_complete_row = (n_row == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_mode    <= csvt_pkg::MODE_PLAIN;
            r_pos     <= '0;
            r_fstart  <= '0;
            r_fquoted <= 1'b0;
            r_fidx    <= '0;
            r_row     <= '0;
            r_rstart  <= '0;
            r_prev_cr <= 1'b0;
        end else if (i_step) begin
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_fstart  <= n_fstart;
            r_fquoted <= n_fquoted;
            r_fidx    <= n_fidx;
            r_row     <= n_row;
            r_rstart  <= n_rstart;
            r_prev_cr <= n_prev_cr;
        end
    end

endmodule

### sv/csvt_checker.sv
// csvt_checker: port-level assertions for csv_field_tokenizer, bound to the top.
// Depends on csvt_pkg and csv_field_tokenizer.
module csvt_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [csvt_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata,
    input logic [csvt_pkg::TUSER_OUT_BITS-1:0] m_axis_tuser,
    input logic                                m_axis_tlast
);

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[0] || m_axis_tlast))
        else $error("result transfer with neither field nor summary");

    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tdata[177] == (m_axis_tdata[176:145] == 32'd0)))
        else $error("no_complete_row disagrees with rows_complete");

    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (!m_axis_tuser[1] && m_axis_tdata[112:0] == '0))
        else $error("field bits set without a field");

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (.*);

### tb/csv_field_tokenizer_test.sv
// csv_field_tokenizer_test: self-checking testbench for the CSV field tokenizer.
// Holds a token predictor and scoreboard in a class; tasks drive the stream and APB ports.
// Depends on csvt_pkg and csv_field_tokenizer.
module csv_field_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 185;

    class csv_token_checker;
        logic [7:0]      quote_c, esc_c, delim_c;
        csvt_pkg::t_mode mode;
        logic [31:0]     pos, fld_start, row_idx, row_start;
        logic [15:0]     fld_idx;
        logic            fld_quoted, prev_cr;
        csvt_pkg::t_res  expected_tokens[$];
        int unsigned     errors;

        function new();
            quote_c = csvt_pkg::QUOTE_RST;
            esc_c   = csvt_pkg::ESC_RST;
            delim_c = csvt_pkg::DELIM_RST;
            errors  = 0;
            clear_buffer();
        endfunction

        function void clear_buffer();
            mode       = csvt_pkg::MODE_PLAIN;
            pos        = '0;
            fld_start  = '0;
            fld_quoted = 1'b0;
            fld_idx    = '0;
            row_idx    = '0;
            row_start  = '0;
            prev_cr    = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                csvt_pkg::REG_QUOTE: quote_c = v;
                csvt_pkg::REG_ESC:   esc_c = v;
                csvt_pkg::REG_DELIM: delim_c = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [7:0]     esc;
            logic           plain, close_f, close_r;
            logic [31:0]    p, len;
            csvt_pkg::t_res r;
            esc = (esc_c != 8'd0) ? esc_c : quote_c;
            p = pos;
            plain = 1'b0;
            close_f = 1'b0;
            close_r = 1'b0;
            r = '0;
            case (mode)
                csvt_pkg::MODE_QUOTED: begin
                    if (b == quote_c || b == esc) begin
                        if (quote_c == esc) mode = csvt_pkg::MODE_QPEND;
                        else if (b == quote_c) mode = csvt_pkg::MODE_PLAIN;
                        else mode = csvt_pkg::MODE_EPEND;
                    end
                end
                csvt_pkg::MODE_QPEND: begin
                    if (b == quote_c) begin
                        mode = csvt_pkg::MODE_QUOTED;
                    end else begin
                        mode = csvt_pkg::MODE_PLAIN;
                        plain = 1'b1;
                    end
                end
                csvt_pkg::MODE_EPEND: mode = csvt_pkg::MODE_QUOTED;
                default: plain = 1'b1;
            endcase
            if (plain) begin
                if (b == quote_c) begin
                    fld_quoted = 1'b1;
                    mode = csvt_pkg::MODE_QUOTED;
                end else if (b == delim_c) begin
                    close_f = 1'b1;
                end else if (b == csvt_pkg::CHAR_LF) begin
                    close_f = 1'b1;
                    close_r = 1'b1;
                end
            end
            if (close_f) begin
                len = p - fld_start;
                if (close_r && len != 0 && prev_cr) len = len - 32'd1;
                r.field_valid  = 1'b1;
                r.field_start  = fld_start;
                r.field_length = len;
                r.field_quoted = fld_quoted;
                r.field_index  = fld_idx;
                r.row_index    = row_idx;
                r.row_end      = close_r;
                fld_start  = sat_inc(p);
                fld_quoted = 1'b0;
                if (close_r) begin
                    fld_idx   = '0;
                    row_idx   = sat_inc(row_idx);
                    row_start = sat_inc(p);
                end else if (fld_idx != 16'hFFFF) begin
                    fld_idx = fld_idx + 16'd1;
                end
            end
            prev_cr = (b == csvt_pkg::CHAR_CR);
            pos = sat_inc(p);
            if (last) begin
                r.buffer_done     = 1'b1;
                r.consumed_bytes  = row_start;
                r.rows_complete   = row_idx;
                r.no_complete_row = (row_idx == 0);
                clear_buffer();
            end
            if (r.field_valid || r.buffer_done) expected_tokens.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch in %s: expected %h, got %h", name, want, got);
            end
        endfunction

        function void check_token(logic [csvt_pkg::TDATA_OUT_BITS-1:0] d, logic [1:0] u,
                                  logic l);
            csvt_pkg::t_res want;
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result transfer: %h %b %b", d, u, l);
                return;
            end
            want = expected_tokens.pop_front();
            compare("field_valid", want.field_valid, u[0]);
            compare("field_start", want.field_start, d[31:0]);
            compare("field_length", want.field_length, d[63:32]);
            compare("field_quoted", want.field_quoted, d[64]);
            compare("field_index", want.field_index, d[80:65]);
            compare("row_index", want.row_index, d[112:81]);
            compare("row_end", want.row_end, u[1]);
            compare("buffer_done", want.buffer_done, l);
            compare("consumed_bytes", want.consumed_bytes, d[144:113]);
            compare("rows_complete", want.rows_complete, d[176:145]);
            compare("no_complete_row", want.no_complete_row, d[177]);
        endfunction
    endclass

    logic                                   i_clk = 1'b0;
    logic                                   i_rst_n;
    logic                                   s_axis_tvalid;
    logic                                   s_axis_tready;
    logic [csvt_pkg::TDATA_IN_BITS-1:0]     s_axis_tdata;
    logic                                   s_axis_tlast;
    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready;
    logic [csvt_pkg::TDATA_OUT_BITS-1:0]    m_axis_tdata;
    logic [csvt_pkg::TUSER_OUT_BITS-1:0]    m_axis_tuser;
    logic                                   m_axis_tlast;
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [csvt_pkg::APB_ADDR_BITS-1:0]     paddr;
    logic [csvt_pkg::APB_DATA_BITS-1:0]     pwdata;
    logic [csvt_pkg::APB_DATA_BITS-1:0]     prdata;
    logic                                   pready;

    csv_token_checker sb;
    logic [7:0]       text[$];
    int               idle_mode = 0;
    int               hold_reqs = 0;
    int               bytes_sent = 0;

    logic [7:0] cfg_quote [8] = '{8'd34, 8'd39, 8'd34, 8'd255, 8'd0,   8'd44, 8'd34, 8'd34};
    logic [7:0] cfg_esc   [8] = '{8'd0,  8'd92, 8'd0,  8'd0,   8'd255, 8'd0,  8'd34, 8'd44};
    logic [7:0] cfg_delim [8] = '{8'd44, 8'd59, 8'd9,  8'd0,   8'd255, 8'd44, 8'd10, 8'd44};

    csv_field_tokenizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stalls per phase, long hold-off on request
    initial begin
        int holds_seen;
        int hold_left;
        holds_seen = 0;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != holds_seen) begin
                holds_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_mode == 2) begin
                m_axis_tready <= ($urandom_range(99) >= 80);
            end else if (idle_mode == 3) begin
                m_axis_tready <= ($urandom_range(99) >= 25);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_byte(logic [7:0] b, logic last);
        if (idle_mode == 1 || idle_mode == 3) begin
            while ($urandom_range(99) < ((idle_mode == 1) ? 80 : 25)) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic void load_string(string s);
        text.delete();
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(6))
            0: return sb.quote_c;
            1: return sb.esc_c;
            2: return sb.delim_c;
            3: return csvt_pkg::CHAR_LF;
            4: return csvt_pkg::CHAR_CR;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        if ($urandom_range(7) == 0) return 8'($urandom_range(255));
        return 8'("a" + $urandom_range(25));
    endfunction

    function automatic void add_field();
        logic [7:0] q, e;
        int n;
        q = sb.quote_c;
        e = (sb.esc_c != 8'd0) ? sb.esc_c : q;
        n = $urandom_range(5);
        if ($urandom_range(2) == 0) begin
            text.push_back(q);
            repeat (n) begin
                case ($urandom_range(7))
                    0: text.push_back(sb.delim_c);
                    1: text.push_back(csvt_pkg::CHAR_LF);
                    2: text.push_back(csvt_pkg::CHAR_CR);
                    3: begin
                        text.push_back(e);
                        text.push_back((e == q || $urandom_range(1) == 0) ? q : e);
                    end
                    4: begin
                        text.push_back(e);
                        if (e != q) text.push_back(plain_byte());
                        else text.push_back(q);
                    end
                    default: text.push_back(plain_byte());
                endcase
            end
            text.push_back(q);
        end else begin
            repeat (n) begin
                if (e != q && $urandom_range(9) == 0) text.push_back(e);
                else text.push_back(plain_byte());
            end
        end
    endfunction

    function automatic void build_buffer();
        int rows, fields;
        text.delete();
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 30)) text.push_back(noise_byte());
            return;
        end
        rows = $urandom_range(3);
        repeat (rows) begin
            fields = $urandom_range(1, 4);
            for (int f = 0; f < fields; f++) begin
                add_field();
                if (f < fields - 1) text.push_back(sb.delim_c);
            end
            if ($urandom_range(1) == 0) text.push_back(csvt_pkg::CHAR_CR);
            text.push_back(csvt_pkg::CHAR_LF);
        end
        if (rows == 0 || $urandom_range(2) == 0) add_field();
        if (text.size() == 0) text.push_back(noise_byte());
    endfunction

    initial begin
        int start;
        sb = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: escaped quotes, CR trim, empty field, quote then other byte
        load_string("a,\"b\"\"c,d\"\015\012,\"q\"z\012");
        send_text();
        // unfinished buffer with no complete row, byte extremes
        text = {8'hFF, 8'h00};
        send_text();
        wait_idle();
        // separate escape byte: outside quotes, before quote, before other byte
        apb_write(csvt_pkg::REG_ESC, 8'd92);
        load_string("\\,\"\\\"\\y\"\012");
        send_text();

        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            apb_write(csvt_pkg::REG_QUOTE, cfg_quote[ph]);
            apb_write(csvt_pkg::REG_ESC, cfg_esc[ph]);
            apb_write(csvt_pkg::REG_DELIM, cfg_delim[ph]);
            idle_mode = ph % 4;
            if (ph == 0) begin
                // hold the result side while a field-dense buffer keeps arriving
                hold_reqs++;
                text.delete();
                repeat (40) begin
                    text.push_back("a");
                    text.push_back(sb.delim_c);
                end
                text.push_back(csvt_pkg::CHAR_LF);
                send_text();
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                build_buffer();
                send_text();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.errors += sb.expected_tokens.size();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
